// ===== rtl/core/xm_pattern_unpacker_unit_assert.svh =====
// assertion macros for the unpacker rtl
`ifndef XM_PATTERN_UNPACKER_UNIT_ASSERT_SVH
`define XM_PATTERN_UNPACKER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define XMPU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xmpu same-cycle check failed");

// next-cycle implication
`define XMPU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xmpu next-cycle check failed");

`endif

// ===== rtl/core/xmpu_pkg.sv =====
`default_nettype none

package xmpu_pkg;

    localparam int MAX_CHANNELS = 32;
    localparam int MAX_ROWS     = 256;

    localparam int BYTE_W  = 8;
    localparam int FIELD_N = 5;
    localparam int CH_W    = 5;
    localparam int ROW_W   = 8;
    localparam int CNT_W   = 6;

    // tdata of the result: five fields, channel, row, padded to whole bytes
    localparam int OUT_RAW_W  = FIELD_N * BYTE_W + CH_W + ROW_W;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

    // channel count saturates at 32 or at MAX_CHANNELS, whichever is smaller
    localparam int CHANNEL_LIMIT = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;

    localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST = CNT_W'(8);
    localparam logic [CNT_W-1:0]   CHANNEL_CAP       = CNT_W'(CHANNEL_LIMIT);
    localparam int                 MASK_FLAG_BIT     = 7;
    localparam logic [FIELD_N-1:0] NOTE_FOLLOWERS    = 5'h1E;
    localparam logic [BYTE_W-1:0]  EFFECT_BREAK      = 8'h0D;

    // field slots in the cell
    localparam int FLD_NOTE   = 0;
    localparam int FLD_INSTR  = 1;
    localparam int FLD_VOLUME = 2;
    localparam int FLD_EFFECT = 3;
    localparam int FLD_PARAM  = 4;

    typedef logic [FIELD_N-1:0][BYTE_W-1:0] t_fields;

    typedef struct packed {
        logic done;       // cell complete after this byte
        logic truncated;  // completed by the last byte with fields missing
        logic brk;        // masked cell carrying the pattern break effect
        logic busy;       // fields still expected before this byte
    } t_asm_stat;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [ROW_W-1:0] row;
        logic             pattern_end;
    } t_pos;

endpackage

`default_nettype wire

// ===== rtl/core/xmpu_cell_asm.sv =====
`default_nettype none

module xmpu_cell_asm (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic [xmpu_pkg::BYTE_W-1:0] i_byte,
    input  wire logic                        i_last,
    output xmpu_pkg::t_fields                o_cell,
    output xmpu_pkg::t_asm_stat              o_stat
);

    logic [xmpu_pkg::FIELD_N-1:0] r_pending, n_pending, w_low;
    logic                         r_masked, n_masked;
    xmpu_pkg::t_fields            r_cell, n_cell;

    assign w_low = r_pending & (~r_pending + xmpu_pkg::FIELD_N'(1));

    always_comb begin
        n_pending = r_pending;
        n_masked  = r_masked;
        n_cell    = r_cell;
        if (r_pending == '0) begin
            n_cell = '0;
            if (i_byte[xmpu_pkg::MASK_FLAG_BIT]) begin
                n_masked  = 1'b1;
                n_pending = i_byte[xmpu_pkg::FIELD_N-1:0];
            end else begin
                n_masked                   = 1'b0;
                n_cell[xmpu_pkg::FLD_NOTE] = i_byte;
                n_pending                  = xmpu_pkg::NOTE_FOLLOWERS;
            end
        end else begin
            // lowest pending field takes the byte
            for (int k = 0; k < xmpu_pkg::FIELD_N; k++) begin
                if (w_low[k]) begin
                    n_cell[k] = i_byte;
                end
            end
            n_pending = r_pending & ~w_low;
        end
    end

    assign o_cell         = n_cell;
    assign o_stat.done      = (n_pending == '0) || i_last;
    assign o_stat.truncated = (n_pending != '0);
    assign o_stat.brk       = n_masked &&
                              (n_cell[xmpu_pkg::FLD_EFFECT] == xmpu_pkg::EFFECT_BREAK);
    assign o_stat.busy      = (r_pending != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_masked  <= 1'b0;
        end else if (i_en) begin
            r_pending <= o_stat.done ? '0 : n_pending;
            r_masked  <= n_masked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/xmpu_pos.sv =====
`default_nettype none

module xmpu_pos (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_last,
    input  wire logic [xmpu_pkg::CNT_W-1:0] i_count,
    input  xmpu_pkg::t_asm_stat             i_stat,
    output logic                            o_drop,
    output xmpu_pkg::t_pos                  o_pos
);

    logic [xmpu_pkg::CH_W-1:0]  r_ch;
    logic [xmpu_pkg::ROW_W-1:0] r_row;
    logic                       r_brk;
    logic                       r_drop;
    logic [xmpu_pkg::CNT_W-1:0] w_eff, w_next_ch;
    logic                       w_wrap, w_row_last, w_brk, w_end;

    // count 0 behaves as 1, large counts saturate
    always_comb begin
        w_eff = i_count;
        if (i_count == '0) begin
            w_eff = xmpu_pkg::CNT_W'(1);
        end else if (i_count > xmpu_pkg::CHANNEL_CAP) begin
            w_eff = xmpu_pkg::CHANNEL_CAP;
        end
    end

    assign w_next_ch  = {1'b0, r_ch} + xmpu_pkg::CNT_W'(1);
    assign w_wrap     = (w_next_ch >= w_eff);
    assign w_row_last = (r_row == xmpu_pkg::ROW_W'(xmpu_pkg::MAX_ROWS - 1));
    assign w_brk      = r_brk || i_stat.brk;
    assign w_end      = i_last || (w_wrap && (w_brk || w_row_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= '0;
            r_row  <= '0;
            r_brk  <= 1'b0;
            r_drop <= 1'b0;
        end else if (i_en) begin
            if (r_drop) begin
                if (i_last) begin
                    r_drop <= 1'b0;
                    r_ch   <= '0;
                    r_row  <= '0;
                    r_brk  <= 1'b0;
                end
            end else if (i_stat.done) begin
                if (w_end) begin
                    r_ch   <= '0;
                    r_row  <= '0;
                    r_brk  <= 1'b0;
                    r_drop <= !i_last;
                end else if (w_wrap) begin
                    r_ch  <= '0;
                    r_row <= r_row + xmpu_pkg::ROW_W'(1);
                    r_brk <= 1'b0;
                end else begin
                    r_ch  <= w_next_ch[xmpu_pkg::CH_W-1:0];
                    r_brk <= w_brk;
                end
            end
        end
    end

    assign o_drop            = r_drop;
    assign o_pos.channel     = r_ch;
    assign o_pos.row         = r_row;
    assign o_pos.pattern_end = w_end;

endmodule

`default_nettype wire

// ===== rtl/core/xm_pattern_unpacker_unit.sv =====
// output path: the byte that completes a cell passes the input register, and its result
//   is shown on the master side from the result register once that register is free
// throughput: one byte per cycle when not back-pressured, set by the single input
//   register feeding the result register through the cell assembly and position logic
// reset: synchronous active low, clears all control state, channel count back to 8
`default_nettype none
`include "xm_pattern_unpacker_unit_assert.svh"

module xm_pattern_unpacker_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // channel count configuration
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [xmpu_pkg::CNT_W-1:0]      i_cfg_data,
    // packed byte stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [xmpu_pkg::BYTE_W-1:0]     s_axis_tdata,   // data_byte
    input  wire logic                            s_axis_tlast,   // last_byte
    // decoded cells
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // note, instrument, volume, effect, param, channel, row, zero pad
    output logic [xmpu_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,   // pattern_end
    output logic                                 m_axis_tuser    // truncated
);

    // configuration register, always ready; writes must come only while idle, which the block itself does not enforce
    logic [xmpu_pkg::CNT_W-1:0] r_chan_cnt;

    // input register
    logic                        r_in_valid;
    logic [xmpu_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_last;

    // result register
    logic                            r_out_valid;
    logic [xmpu_pkg::OUT_DATA_W-1:0] r_out_data;
    logic                            r_out_last;
    logic                            r_out_user;

    logic                 w_fire;   // byte in the input register is processed
    logic                 w_drop;   // pattern ended, bytes skipped until last
    logic                 w_emit;   // processed byte completes a cell
    xmpu_pkg::t_fields    w_cell;
    xmpu_pkg::t_asm_stat  w_stat;
    xmpu_pkg::t_pos       w_pos;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= xmpu_pkg::CHANNEL_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_chan_cnt <= i_cfg_data;
        end
    end

    // the input stage moves on whenever the result register is free or drains
    assign w_fire        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_fire;
    assign w_emit        = w_fire && !w_drop && w_stat.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // cell assembly from mask, note and field bytes
    xmpu_cell_asm u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire && !w_drop),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_cell  (w_cell),
        .o_stat  (w_stat)
    );

    // channel and row tracking, break and end of pattern
    xmpu_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_last  (r_in_last),
        .i_count (r_chan_cnt),
        .i_stat  (w_stat),
        .o_drop  (w_drop),
        .o_pos   (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {{xmpu_pkg::OUT_PAD_W{1'b0}},
                           w_pos.row,
                           w_pos.channel,
                           w_cell[xmpu_pkg::FLD_PARAM],
                           w_cell[xmpu_pkg::FLD_EFFECT],
                           w_cell[xmpu_pkg::FLD_VOLUME],
                           w_cell[xmpu_pkg::FLD_INSTR],
                           w_cell[xmpu_pkg::FLD_NOTE]};
            r_out_last <= w_pos.pattern_end;
            r_out_user <= w_stat.truncated;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    // a truncated cell always closes the pattern
    `XMPU_ASSERT_IMP(a_trunc_ends, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
    // while skipping bytes no cell is half assembled
    `XMPU_ASSERT_IMP(a_drop_idle, w_drop, !w_stat.busy)
    // after the closing cell the position restarts at channel 0, row 0
    `XMPU_ASSERT_NXT(a_end_restart, w_emit && w_pos.pattern_end,
                     (w_pos.channel == '0) && (w_pos.row == '0))

endmodule

`default_nettype wire

// ===== verif/xmpu_cell_checker.sv =====
module xmpu_cell_checker
    import xmpu_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CNT_W-1:0]      i_cfg_data,
    input  wire logic                  i_s_valid,
    input  wire logic                  i_s_ready,
    input  wire logic [BYTE_W-1:0]     i_s_data,   // data_byte
    input  wire logic                  i_s_last,   // last_byte
    input  wire logic                  i_m_valid,
    input  wire logic                  i_m_ready,
    // note, instrument, volume, effect, param, channel, row, zero pad
    input  wire logic [OUT_DATA_W-1:0] i_m_data,
    input  wire logic                  i_m_last,   // pattern_end
    input  wire logic                  i_m_user,   // truncated
    output int                         o_errors,
    output int                         o_pending
);

    typedef struct packed {
        t_fields          fields;
        logic [CH_W-1:0]  channel;
        logic [ROW_W-1:0] row;
        logic             pattern_end;
        logic             truncated;
    } decoded_cell_t;

    string field_names [FIELD_N] = '{"note", "instrument", "volume", "effect", "param"};

    // decoder state as the block should hold it
    logic [CNT_W-1:0]   chan_setting;
    logic [FIELD_N-1:0] fields_wanted;
    t_fields            cell_acc;
    bit                 cell_from_mask;
    int unsigned        chan_pos;
    int unsigned        row_pos;
    bit                 break_in_row;
    bit                 dropping;

    decoded_cell_t cells_due [$];
    int            mismatches = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic int unsigned active_channels();
        int unsigned c;
        c = chan_setting;
        if (c < 1) c = 1;
        if (c > 32) c = 32;
        if (c > MAX_CHANNELS) c = MAX_CHANNELS;
        return c;
    endfunction

    task automatic restart_pattern();
        fields_wanted  = '0;
        cell_acc       = '0;
        cell_from_mask = 1'b0;
        chan_pos       = 0;
        row_pos        = 0;
        break_in_row   = 1'b0;
    endtask

    // one accepted byte, queues the cell it completes
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
        decoded_cell_t c;
        bit            placed;
        bit            row_done;
        bit            finish;
        if (dropping) begin
            if (last) begin
                dropping = 1'b0;
                restart_pattern();
            end
            return;
        end
        if (fields_wanted == '0) begin
            cell_acc = '0;
            if (b[MASK_FLAG_BIT]) begin
                cell_from_mask = 1'b1;
                fields_wanted  = b[FIELD_N-1:0];
            end else begin
                cell_from_mask     = 1'b0;
                cell_acc[FLD_NOTE] = b;
                fields_wanted      = NOTE_FOLLOWERS;
            end
        end else begin
            placed = 1'b0;
            for (int k = 0; k < FIELD_N; k++) begin
                if (!placed && fields_wanted[k]) begin
                    cell_acc[k]      = b;
                    fields_wanted[k] = 1'b0;
                    placed           = 1'b1;
                end
            end
        end
        if (fields_wanted != '0 && !last) return;

        c.truncated   = (fields_wanted != '0);
        fields_wanted = '0;
        if (cell_from_mask && cell_acc[FLD_EFFECT] == EFFECT_BREAK) break_in_row = 1'b1;
        c.fields  = cell_acc;
        c.channel = chan_pos[CH_W-1:0];
        c.row     = row_pos[ROW_W-1:0];

        chan_pos++;
        row_done = 1'b0;
        if (chan_pos >= active_channels()) begin
            chan_pos = 0;
            row_pos++;
            row_done = 1'b1;
        end
        finish = last;
        if (row_done) begin
            if (break_in_row || row_pos >= MAX_ROWS) finish = 1'b1;
            break_in_row = 1'b0;
        end
        c.pattern_end = finish;
        cells_due.push_back(c);
        if (finish) begin
            restart_pattern();
            if (!last) dropping = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: cell %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        decoded_cell_t want_cell;
        if (!i_rst_n) begin
            chan_setting = CHANNEL_COUNT_RST;
            dropping     = 1'b0;
            restart_pattern();
            cells_due.delete();
        end else begin
            // an output transfer is always older than a byte accepted at the same edge
            if (i_m_valid && i_m_ready) begin
                if (cells_due.size() == 0) begin
                    $display("%0t: unexpected cell, expected none, got 0x%0h last %b user %b",
                             $time, i_m_data, i_m_last, i_m_user);
                    mismatches++;
                end else begin
                    want_cell = cells_due.pop_front();
                    for (int k = 0; k < FIELD_N; k++)
                        check_field(field_names[k], want_cell.fields[k],
                                    i_m_data[k*BYTE_W +: BYTE_W]);
                    check_field("channel", want_cell.channel,
                                i_m_data[FIELD_N*BYTE_W +: CH_W]);
                    check_field("row", want_cell.row,
                                i_m_data[FIELD_N*BYTE_W+CH_W +: ROW_W]);
                    check_field("pad", 0, i_m_data[OUT_DATA_W-1 -: OUT_PAD_W]);
                    check_field("pattern_end", want_cell.pattern_end, i_m_last);
                    check_field("truncated", want_cell.truncated, i_m_user);
                end
            end
            if (i_cfg_valid && i_cfg_ready) chan_setting = i_cfg_data;
            if (i_s_valid && i_s_ready) decode_byte(i_s_data, i_s_last);
        end
        o_pending <= cells_due.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== verif/tb_xm_pattern_unpacker_unit.sv =====
module tb_xm_pattern_unpacker_unit;
    import xmpu_pkg::*;

    // generous bound, far above the slowest legal run
    localparam int TIMEOUT_CYCLES = 400_000;
    // receiver hold-off used to fill the block and back up the byte stream
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_BYTES    = 100;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;

    // configuration channel
    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CNT_W-1:0]      cfg_data  = '0;

    // byte stream into the block
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;   // data_byte
    logic                  s_tlast  = 1'b0; // last_byte

    // decoded cells out of the block
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire [OUT_DATA_W-1:0]  m_tdata;         // note, instrument, volume, effect, param, channel, row, pad
    wire                   m_tlast;         // pattern_end
    wire                   m_tuser;         // truncated

    int  err_count;
    int  cells_pending;
    bit  idle_on   = 1'b1;  // random gaps on both sides
    bit  stall_req = 1'b0;  // asks the receiver for its one long hold-off
    int  bytes_sent = 0;

    xm_pattern_unpacker_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    xmpu_cell_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_s_valid   (s_tvalid),
        .i_s_ready   (s_tready),
        .i_s_data    (s_tdata),
        .i_s_last    (s_tlast),
        .i_m_valid   (m_tvalid),
        .i_m_ready   (m_tready),
        .i_m_data    (m_tdata),
        .i_m_last    (m_tlast),
        .i_m_user    (m_tuser),
        .o_errors    (err_count),
        .o_pending   (cells_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * TIMEOUT_CYCLES);
        $display("[xm_pattern_unpacker_unit] ERROR");
        $finish;
    end

    // receiver: random back-pressure plus one long hold-off counted here
    initial begin : rx_side
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (int n = 0; n < RX_HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 7);
            end
        end
    end

    // offer one byte and return at the edge of its transfer; tvalid stays up
    // so back-to-back bytes never lower and raise it in one step
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while (idle_on && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // sender pause: stop offering and wait until every cell has come out
    task automatic wait_cells_drained();
        s_tvalid <= 1'b0;
        // the count is registered in the checker and lags behind its queue
        @(posedge i_clk);
        while (cells_pending != 0) @(posedge i_clk);
        // bytes that complete no cell may still sit in the input register
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_channel_count(input logic [CNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // field content, with the break effect mixed in now and then
    function automatic logic [BYTE_W-1:0] field_byte(input int slot);
        if (slot == FLD_EFFECT && $urandom_range(99) < 8) return EFFECT_BREAK;
        return BYTE_W'($urandom_range(255));
    endfunction

    // mostly well-formed cells, some stray bytes, some cut short by the last flag
    task automatic send_cell();
        logic [BYTE_W-1:0]  seq [$];
        logic [FIELD_N-1:0] mask;
        int                 cut;
        bit                 end_flag;
        if ($urandom_range(99) < 10) begin
            send_byte(BYTE_W'($urandom_range(255)), $urandom_range(99) < 5);
            return;
        end
        if ($urandom_range(99) < 30) begin
            // note form: note byte then the four other fields
            seq.push_back(BYTE_W'($urandom_range(127)));
            for (int k = FLD_INSTR; k < FIELD_N; k++) seq.push_back(field_byte(k));
        end else begin
            // mask form; bits 5 and 6 of the mask byte are don't care
            mask = FIELD_N'($urandom);
            seq.push_back({1'b1, 2'($urandom), mask});
            for (int k = 0; k < FIELD_N; k++)
                if (mask[k]) seq.push_back(field_byte(k));
        end
        cut      = seq.size() - 1;
        end_flag = ($urandom_range(99) < 6);
        if (seq.size() > 1 && $urandom_range(99) < 3) begin
            cut      = $urandom_range(seq.size() - 2);
            end_flag = 1'b1;
        end
        for (int k = 0; k <= cut; k++) send_byte(seq[k], end_flag && k == cut);
    endtask

    initial begin : stim
        logic [CNT_W-1:0] counts [8];
        counts = '{6'd32, 6'd3, 6'd0, 6'd63, 6'd40, 6'd5,
                   CNT_W'($urandom_range(63)), CNT_W'($urandom_range(63))};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset channel count of 8
        // note-form cell with extreme fields and an unmasked break that must not end
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(EFFECT_BREAK, 1'b0);
        send_byte(8'hFF, 1'b0);
        // empty mask is a complete all-zero cell
        send_byte(8'h80, 1'b0);
        // full mask
        send_byte(8'h9F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h40, 1'b0);
        send_byte(8'h0C, 1'b0);
        send_byte(8'hAA, 1'b0);
        // masked break, pattern ends with the row at channel 7
        send_byte(8'h88, 1'b0);
        send_byte(EFFECT_BREAK, 1'b0);
        repeat (4) send_byte(8'h80, 1'b0);
        // dropped after the break, the flagged byte clears the drop
        send_byte(8'h12, 1'b0);
        send_byte(8'hE5, 1'b0);
        send_byte(8'h80, 1'b1);
        // stream ends inside a masked cell, then inside a note-form cell
        send_byte(8'h83, 1'b0);
        send_byte(8'h61, 1'b1);
        send_byte(8'h7F, 1'b1);
        wait_cells_drained();

        // random phases, each under its own channel count
        for (int ph = 0; ph < 8; ph++) begin
            write_channel_count(counts[ph]);
            if (ph == 2) stall_req <= 1'b1;
            idle_on <= (ph != 4);
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) send_cell();
            wait_cells_drained();
        end

        // row limit: one channel per row, 256 empty cells end the pattern
        write_channel_count(6'd1);
        send_byte(8'h80, 1'b1);  // restart from row 0 whatever the state
        repeat (MAX_ROWS) send_byte(8'h80, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h80, 1'b1);
        send_cell();
        send_byte(8'hC4, 1'b0);
        send_byte(8'h21, 1'b1);
        wait_cells_drained();

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[xm_pattern_unpacker_unit] OK");
        end else begin
            $display("[xm_pattern_unpacker_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== xm_pattern_unpacker_unit.f =====
+incdir+rtl/core
rtl/core/xmpu_pkg.sv
rtl/core/xmpu_cell_asm.sv
rtl/core/xmpu_pos.sv
rtl/core/xm_pattern_unpacker_unit.sv
verif/xmpu_cell_checker.sv
verif/tb_xm_pattern_unpacker_unit.sv
